// ===== sv/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Page frame replacement package
// Widths, codes, memory entry and result types, and the state encoding
// shared by the replacement unit and its submodules.
// ----------------------------------------------------------------------------
package pfr_pkg;

	localparam int ADDR_W  = 12;
	localparam int PAGE_W  = 9;
	localparam int AGE_W   = 16;
	localparam int COUNT_W = 16;
	localparam int FIDX_W  = 2;

	// Page is address / 10, done as a multiply by ceil(2^16 / 10) and a
	// shift; exact for every 12-bit address.
	localparam int RECIP_W = 13;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 13'd6554;
	localparam int PROD_W = ADDR_W + RECIP_W;
	localparam int DIV_SHIFT = 16;

	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [AGE_W-1:0]  age;
	} pfr_entry_t;

	typedef struct packed {
		logic               page_fault;
		logic [FIDX_W-1:0]  frame_index;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
		logic [COUNT_W-1:0] fault_total;
	} pfr_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIX,
		ST_WAIT
	} pfr_state_t;

	function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] v);
		return (v == {AGE_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

// ===== sv/pfr_ifs.sv =====
// ----------------------------------------------------------------------------
// Page frame replacement channels
// Valid/ready channels for reference items, result items and the policy
// register write.
// ----------------------------------------------------------------------------
interface pfr_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] ref_address;

	modport source (output valid, output ref_address, input ready);
	modport sink (input valid, input ref_address, output ready);
endinterface

interface pfr_out_if;
	logic        valid;
	logic        ready;
	logic        page_fault;
	logic [1:0]  frame_index;
	logic        evicted_valid;
	logic [8:0]  evicted_page;
	logic [15:0] fault_total;

	modport source (output valid, output page_fault, output frame_index,
		output evicted_valid, output evicted_page, output fault_total, input ready);
	modport sink (input valid, input page_fault, input frame_index,
		input evicted_valid, input evicted_page, input fault_total, output ready);
endinterface

interface pfr_cfg_if;
	logic valid;
	logic ready;
	logic policy_mode;

	modport source (output valid, output policy_mode, input ready);
	modport sink (input valid, input policy_mode, output ready);
endinterface

// ===== sv/page_frame_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// Page frame replacement unit
// Least recently used or first in first out replacement over FRAMES frames.
// ----------------------------------------------------------------------------
// Usage: each item on req carries one reference address; the unit turns it
// into a page (address / 10) and answers with exactly one item on rsp that
// gives the fault flag, the frame now holding the page, the evicted page and
// the running fault count. cfg writes the policy bit (0 LRU, 1 FIFO); it is
// always ready and is meant to be written only while the unit is idle.
// Sequence: an accepted item passes through ST_SCAN, ST_FIX and ST_WAIT,
// and its result is loaded into the output register from ST_WAIT. The cost is
// set by the frame memory's single read port: the sequencer reads one frame
// per cycle in ST_SCAN, compares it and writes its aged entry back, then in
// ST_FIX loads the chosen frame on a fault or refreshes it on an LRU hit, and
// in ST_WAIT hands the result over once the output register can take it.
// A new item is taken once the previous result is in the output register, so
// the next item may start before the receiver has taken the last result.
// Reset clears the valid bits, counters and policy; the frame memory itself
// is not cleared, since a frame that was never loaded is not read for its page
// and its age is derived from the reference count. When rsp is stalled, the
// result holds in the output register and the sequencer waits after its work.
// ----------------------------------------------------------------------------
module page_frame_replacement_unit #(
	parameter int FRAMES = 4
) (
	input logic      clk,
	input logic      arst_n,
	pfr_in_if.sink   req,
	pfr_out_if.source rsp,
	pfr_cfg_if.sink  cfg
);
	import pfr_pkg::*;

	localparam int IDX_W = $clog2(FRAMES);

	logic               policy_q;
	logic [PAGE_W-1:0]  page_q;
	logic [PROD_W-1:0]  product;
	logic               start, idle, res_valid, res_take;
	logic               rsp_valid_q;
	pfr_result_t        result, rsp_data_q;

	logic               mem_wr_en;
	logic [IDX_W-1:0]   mem_wr_addr, mem_rd_addr;
	pfr_entry_t         mem_wr_data, mem_rd_data;

	// Policy register; a write is taken at any time.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_LRU;
		end else if (cfg.valid) begin
			policy_q <= cfg.policy_mode;
		end
	end

	// Page number by reciprocal multiplication, registered at acceptance.
	assign req.ready = idle;
	assign start     = req.valid && idle;
	assign product   = PROD_W'(req.ref_address) * PROD_W'(DIV_RECIP);

	always_ff @(posedge clk) begin
		if (start) begin
			page_q <= product[DIV_SHIFT +: PAGE_W];
		end
	end

	pfr_ctrl #(
		.FRAMES (FRAMES),
		.IDX_W  (IDX_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.page        (page_q),
		.policy_mode (policy_q),
		.idle        (idle),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.result      (result),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	pfr_frame_mem #(
		.FRAMES (FRAMES),
		.IDX_W  (IDX_W)
	) u_frame_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Output register: the result moves in once the previous one has gone.
	assign res_take = res_valid && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_data_q <= result;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.page_fault    = rsp_data_q.page_fault;
	assign rsp.frame_index   = rsp_data_q.frame_index;
	assign rsp.evicted_valid = rsp_data_q.evicted_valid;
	assign rsp.evicted_page  = rsp_data_q.evicted_page;
	assign rsp.fault_total   = rsp_data_q.fault_total;

`ifndef SYNTH
	// Only one item is in the sequencer at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second item accepted while one is in work");

	// The reciprocal divide must land on a page below 410.
	a_page_range: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (page_q <= 9'd409))
		else $error("page number out of range");

	// An eviction only ever comes with a fault.
	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (!rsp.evicted_valid || rsp.page_fault))
		else $error("eviction reported without a fault");

	// A result never overwrites one that the receiver has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> $stable(rsp.fault_total))
		else $error("pending result overwritten");
`endif

endmodule

// ===== sv/pfr_frame_mem.sv =====
// ----------------------------------------------------------------------------
// Frame memory
// One-write, one-read synchronous memory holding page and age per frame,
// with registered read data.
// ----------------------------------------------------------------------------
module pfr_frame_mem #(
	parameter int FRAMES = 4,
	parameter int IDX_W  = 2
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  pfr_pkg::pfr_entry_t wr_data,
	input  logic [IDX_W-1:0]   rd_addr,
	output pfr_pkg::pfr_entry_t rd_data
);
	import pfr_pkg::*;

	pfr_entry_t mem_q [FRAMES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/pfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Replacement sequencer
// Scans the frame memory for hit, empty frame and oldest frame, ages each
// entry on the way, then loads or, under LRU, refreshes the chosen frame.
// ----------------------------------------------------------------------------
module pfr_ctrl #(
	parameter int FRAMES = 4,
	parameter int IDX_W  = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pfr_pkg::PAGE_W-1:0] page,
	input  logic                       policy_mode,
	output logic                       idle,
	output logic                       res_valid,
	input  logic                       res_take,
	output pfr_pkg::pfr_result_t       result,
	output logic                       mem_wr_en,
	output logic [IDX_W-1:0]           mem_wr_addr,
	output pfr_pkg::pfr_entry_t        mem_wr_data,
	output logic [IDX_W-1:0]           mem_rd_addr,
	input  pfr_pkg::pfr_entry_t        mem_rd_data
);
	import pfr_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

	pfr_state_t state_q, state_d;

	logic [IDX_W-1:0]   cmp_idx_q;
	logic               hit_found_q, empty_found_q;
	logic [IDX_W-1:0]   hit_idx_q, empty_idx_q, oldest_idx_q;
	logic [AGE_W-1:0]   oldest_age_q;
	logic [PAGE_W-1:0]  oldest_page_q;
	logic [FRAMES-1:0]  valid_q;
	logic [AGE_W-1:0]   ref_count_q;
	logic [COUNT_W-1:0] fault_count_q;
	pfr_result_t        result_q;

	logic               ent_valid, ent_hit, fault, evicted;
	logic [AGE_W-1:0]   eff_age;
	logic [IDX_W-1:0]   slot;
	logic [IDX_W+1:0]   slot_ext;

	// A frame never loaded has aged once per reference since reset.
	assign ent_valid = valid_q[cmp_idx_q];
	assign eff_age   = ent_valid ? mem_rd_data.age : ref_count_q;
	assign ent_hit   = ent_valid && (mem_rd_data.page == page);

	assign fault    = !hit_found_q;
	assign evicted  = fault && !empty_found_q;
	assign slot     = hit_found_q ? hit_idx_q : (empty_found_q ? empty_idx_q : oldest_idx_q);
	assign slot_ext = (IDX_W + 2)'(slot);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cmp_idx_q == LAST_IDX) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		idle        = 1'b0;
		res_valid   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = cmp_idx_q;
		mem_wr_data = '{page: mem_rd_data.page, age: sat_inc(eff_age)};
		mem_rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
			end
			ST_SCAN: begin
				mem_wr_en   = 1'b1;
				mem_rd_addr = (cmp_idx_q == LAST_IDX) ? '0 : cmp_idx_q + 1'b1;
			end
			ST_FIX: begin
				mem_wr_en   = fault || (policy_mode == POLICY_LRU);
				mem_wr_addr = slot;
				mem_wr_data = '{page: page, age: '0};
			end
			ST_WAIT: begin
				res_valid = 1'b1;
			end
			default: begin
				idle = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmp_idx_q     <= '0;
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
			valid_q       <= '0;
			ref_count_q   <= '0;
			fault_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				cmp_idx_q     <= '0;
				hit_found_q   <= 1'b0;
				empty_found_q <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				cmp_idx_q <= cmp_idx_q + 1'b1;
				if (!hit_found_q && ent_hit) begin
					hit_found_q <= 1'b1;
				end
				if (!empty_found_q && !ent_valid) begin
					empty_found_q <= 1'b1;
				end
			end
			if (state_q == ST_FIX) begin
				ref_count_q <= sat_inc(ref_count_q);
				if (fault) begin
					valid_q[slot] <= 1'b1;
					fault_count_q <= sat_inc(fault_count_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			if (!hit_found_q && ent_hit) begin
				hit_idx_q <= cmp_idx_q;
			end
			if (!empty_found_q && !ent_valid) begin
				empty_idx_q <= cmp_idx_q;
			end
			// Strictly greater keeps the lowest index on a tie.
			if (cmp_idx_q == '0 || eff_age > oldest_age_q) begin
				oldest_idx_q  <= cmp_idx_q;
				oldest_age_q  <= eff_age;
				oldest_page_q <= mem_rd_data.page;
			end
		end
		if (state_q == ST_FIX) begin
			result_q.page_fault    <= fault;
			result_q.frame_index   <= slot_ext[FIDX_W-1:0];
			result_q.evicted_valid <= evicted;
			result_q.evicted_page  <= evicted ? oldest_page_q : '0;
			result_q.fault_total   <= fault ? sat_inc(fault_count_q) : fault_count_q;
		end
	end

	assign result = result_q;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Page frame replacement unit testbench
// Sends reference items to the replacement unit under both policies and
// predicts every result from its own model of the frames. Each result item
// is checked field by field. The sender leaves random gaps and the receiver
// stalls at random.
// ----------------------------------------------------------------------------
module testbench;

	import pfr_pkg::*;

	localparam int FRAMES = 4;
	localparam int PAGE_SIZE = 10;
	localparam int ADDR_MAX = (1 << ADDR_W) - 1;
	localparam int PAGE_MAX = ADDR_MAX / PAGE_SIZE;
	localparam logic [AGE_W-1:0] AGE_CEIL = '1;
	localparam logic [COUNT_W-1:0] COUNT_CEIL = '1;

	// Six random phases of this size give roughly the intended item count.
	localparam int RANDOM_PHASE_ITEMS = 315;
	// After the last result we watch a little longer for any stray result item.
	localparam int DRAIN_CYCLES = 2 * (FRAMES + 3) + 2;
	// The run sends some 1900 items and is longest where the sender or the
	// receiver idles. The limit allows several times the slowest correct run.
	localparam int CYCLE_LIMIT = 200000;

	// Clock, reset and everything driven into the unit. The initial values
	// hold from time zero, so no input of the unit is ever unknown.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic ref_valid = 1'b0;
	logic [ADDR_W-1:0] ref_addr = '0;
	logic result_ready = 1'b0;
	logic policy_valid = 1'b0;
	logic policy_bit = POLICY_LRU;

	pfr_in_if req_if ();
	pfr_out_if rsp_if ();
	pfr_cfg_if cfg_if ();

	assign req_if.valid = ref_valid;
	assign req_if.ref_address = ref_addr;
	assign rsp_if.ready = result_ready;
	assign cfg_if.valid = policy_valid;
	assign cfg_if.policy_mode = policy_bit;

	page_frame_replacement_unit #(
		.FRAMES(FRAMES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	// Our own copy of the frame table, the fault counter and the policy bit.
	logic               model_valid [FRAMES];
	logic [PAGE_W-1:0]  model_page [FRAMES];
	logic [AGE_W-1:0]   model_age [FRAMES];
	logic [COUNT_W-1:0] model_faults;
	logic               model_policy;

	// Addresses waiting to be sent, and the results owed for items taken.
	logic [ADDR_W-1:0] pending_refs [$];
	pfr_result_t       results_due [$];
	pfr_result_t       due_now;

	// Idle rates in percent. The initial block changes them between phases.
	int unsigned send_gap_pct = 23;
	int unsigned recv_stall_pct = 75;
	int unsigned cycle_count = 0;
	bit          mismatch_seen = 1'b0;

	// The directed references. The first twelve run under LRU and the rest
	// under FIFO. They start on empty frames whose stale page is zero, so the
	// first reference to page 0 must still fault. They then fill the table,
	// force evictions, and touch both address extremes and alternating bits.
	int unsigned directed_refs [20] = '{
		0, 9, 4095, 10, 4094, 20, 30, 9, 1365, 2730, 2047, 2048,
		4090, 19, 0, 3999, 4095, 1, 100, 110
	};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Work out the result of one reference and advance the model. A single
	// scan finds the matching valid frame, the lowest empty frame and the
	// oldest frame. The lowest index wins a tie, because only a strictly
	// greater age takes over. Every age then counts up and holds at the
	// ceiling. A frame loaded on a fault starts again from zero, and so does
	// a frame hit under LRU.
	function automatic pfr_result_t resolve_reference(input logic [ADDR_W-1:0] addr);
		logic [PAGE_W-1:0] page;
		int hit;
		int empty;
		int oldest;
		int slot;
		pfr_result_t res;
		page = PAGE_W'(addr / PAGE_SIZE);
		hit = -1;
		empty = -1;
		oldest = 0;
		res = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (model_valid[i]) begin
				if (hit < 0 && model_page[i] == page)
					hit = i;
			end else if (empty < 0) begin
				empty = i;
			end
			if (model_age[i] > model_age[oldest])
				oldest = i;
		end
		res.page_fault = (hit < 0);
		if (hit >= 0) begin
			slot = hit;
		end else if (empty >= 0) begin
			slot = empty;
		end else begin
			slot = oldest;
			res.evicted_valid = 1'b1;
			res.evicted_page = model_page[oldest];
		end
		for (int i = 0; i < FRAMES; i++) begin
			if (model_age[i] != AGE_CEIL)
				model_age[i] = model_age[i] + 1'b1;
		end
		if (res.page_fault) begin
			model_valid[slot] = 1'b1;
			model_page[slot] = page;
			model_age[slot] = '0;
			if (model_faults != COUNT_CEIL)
				model_faults = model_faults + 1'b1;
		end else if (model_policy == POLICY_LRU) begin
			model_age[slot] = '0;
		end
		res.frame_index = FIDX_W'(slot);
		res.fault_total = model_faults;
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_seen = 1'b1;
		end
	endtask

	// Reference driver. A taken item is predicted at the edge where it is
	// accepted. The next address goes out whenever the slot is free, unless
	// the sender chooses to leave a gap in this cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_valid <= 1'b0;
			ref_addr <= '0;
		end else begin
			if (ref_valid && req_if.ready)
				results_due.push_back(resolve_reference(ref_addr));
			if (!ref_valid || req_if.ready) begin
				if (pending_refs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					ref_valid <= 1'b1;
					ref_addr <= pending_refs.pop_front();
				end else begin
					ref_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Each accepted result item is checked against the
	// oldest one owed. Ready is redrawn every cycle to make the stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (rsp_if.valid && result_ready) begin
				if (results_due.size() == 0) begin
					$error("result item arrived with no reference outstanding");
					mismatch_seen = 1'b1;
				end else begin
					due_now = results_due.pop_front();
					compare_field("page_fault", 32'(due_now.page_fault),
						32'(rsp_if.page_fault));
					compare_field("frame_index", 32'(due_now.frame_index),
						32'(rsp_if.frame_index));
					compare_field("evicted_valid", 32'(due_now.evicted_valid),
						32'(rsp_if.evicted_valid));
					compare_field("evicted_page", 32'(due_now.evicted_page),
						32'(rsp_if.evicted_page));
					compare_field("fault_total", 32'(due_now.fault_total),
						32'(rsp_if.fault_total));
				end
			end
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog. A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Wait until every item has been sent and every result has come back.
	// Each item gives exactly one result, so the unit is then idle.
	task automatic settle();
		while (pending_refs.size() != 0 || ref_valid || results_due.size() != 0)
			@(posedge clk);
	endtask

	// Write the policy register. The model follows at the accepting edge.
	// No item is in flight at that point.
	task automatic write_policy(input logic mode);
		@(posedge clk);
		policy_valid <= 1'b1;
		policy_bit <= mode;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		model_policy = mode;
		policy_valid <= 1'b0;
	endtask

	// Random references with locality. Most come from a small hot set of
	// pages, a bit larger than the frame table, so hits, misses and
	// evictions all occur. Some repeat the last page, and the rest are
	// random pages or fully random addresses.
	task automatic queue_random_refs(input int count);
		int unsigned hot [6];
		int unsigned page;
		int unsigned addr;
		int unsigned roll;
		foreach (hot[i])
			hot[i] = $urandom_range(PAGE_MAX);
		page = hot[0];
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 55)
				page = hot[$urandom_range(5)];
			else if (roll >= 70)
				page = $urandom_range(PAGE_MAX);
			addr = page * PAGE_SIZE + $urandom_range(PAGE_SIZE - 1);
			if (roll >= 85)
				addr = $urandom_range(ADDR_MAX);
			if (addr > ADDR_MAX)
				addr = ADDR_MAX;
			pending_refs.push_back(ADDR_W'(addr));
		end
	endtask

	initial begin
		for (int i = 0; i < FRAMES; i++) begin
			model_valid[i] = 1'b0;
			model_page[i] = '0;
			model_age[i] = '0;
		end
		model_faults = '0;
		model_policy = POLICY_LRU;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: first under LRU, then under FIFO.
		write_policy(POLICY_LRU);
		@(negedge clk);
		for (int i = 0; i < 12; i++)
			pending_refs.push_back(ADDR_W'(directed_refs[i]));
		settle();
		write_policy(POLICY_FIFO);
		@(negedge clk);
		for (int i = 12; i < 20; i++)
			pending_refs.push_back(ADDR_W'(directed_refs[i]));
		settle();

		// Random phases alternate the policy. The first pair has a slow
		// receiver, the second a slow sender, and the last pair no idling.
		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				send_gap_pct = 75;
				recv_stall_pct = 23;
			end else if (p == 4) begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			write_policy((p % 2 == 0) ? POLICY_FIFO : POLICY_LRU);
			@(negedge clk);
			queue_random_refs(RANDOM_PHASE_ITEMS);
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!mismatch_seen && results_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/pfr_pkg.sv
sv/pfr_ifs.sv
sv/pfr_frame_mem.sv
sv/pfr_ctrl.sv
sv/page_frame_replacement_unit.sv
dv/testbench.sv
